FILE: hdl/tjs_pkg.sv
// Shared types, codes and helpers for the two-wire JTAG scan shifter.
// No dependencies; the shift modules and the top file import this package.
`timescale 1ns / 1ps
`default_nettype none

package tjs_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 6;

  localparam logic [WORD_W-1:0] TOP_BIT_8    = 32'h0000_0080;
  localparam logic [WORD_W-1:0] TOP_BIT_16   = 32'h0000_8000;
  localparam logic [WORD_W-1:0] TOP_BIT_20   = 32'h0008_0000;
  localparam logic [WORD_W-1:0] TOP_BIT_32   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] DESCR_MASK   = 32'h000F_FFFF;

  typedef enum logic [1:0] {
    CMD_SHIFT    = 2'd0,
    CMD_SET_TCLK = 2'd1,
    CMD_CLR_TCLK = 2'd2
  } tjs_cmd_e;

  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_20 = 2'd2,
    FMT_32 = 2'd3
  } tjs_fmt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_UPDATE,
    ST_RETURN,
    ST_TCLK
  } tjs_state_e;

  // Control from the sequencer to the serial data paths.
  typedef struct packed {
    logic     load;
    logic     advance;
    tjs_fmt_e fmt;
  } tjs_shift_ctrl_t;

  // Move the used bits of a word up so its first bit sits at bit 31.
  function automatic logic [WORD_W-1:0] align_top(tjs_fmt_e fmt, logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    case (fmt)
      FMT_8:   r = w << 24;
      FMT_16:  r = w << 16;
      FMT_20:  r = w << 12;
      FMT_32:  r = w;
      default: r = w;
    endcase
    return r;
  endfunction

  // Number of data bits minus one.
  function automatic logic [CNT_W-1:0] last_index(tjs_fmt_e fmt);
    logic [CNT_W-1:0] r;
    case (fmt)
      FMT_8:   r = CNT_W'(7);
      FMT_16:  r = CNT_W'(15);
      FMT_20:  r = CNT_W'(19);
      FMT_32:  r = CNT_W'(31);
      default: r = CNT_W'(31);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tjs_if.sv
// Handshake channels of the scan shifter: command in, JTAG cycle beats out.
// Uses nothing from the package; payload widths follow the field list.
`timescale 1ns / 1ps
`default_nettype none

interface tjs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  shift_format;
  logic [31:0] shift_data;
  logic [31:0] target_tdo;

  modport source (output valid, command, shift_format, shift_data, target_tdo,
                  input ready);
  modport sink   (input valid, command, shift_format, shift_data, target_tdo,
                  output ready);
endinterface

interface tjs_slot_if;
  logic        valid;
  logic        ready;
  logic        slot_tms;
  logic        slot_tdi;
  logic        tms_slot_preset_high;
  logic        tdo_sampled;
  logic        last_cycle;
  logic [31:0] captured_word;

  modport source (output valid, slot_tms, slot_tdi, tms_slot_preset_high, tdo_sampled,
                  last_cycle, captured_word, input ready);
  modport sink   (input valid, slot_tms, slot_tdi, tms_slot_preset_high, tdo_sampled,
                  last_cycle, captured_word, output ready);
endinterface

`default_nettype wire

FILE: hdl/tjs_tdi_shifter.sv
// TDI serializer: a 32-bit shift register that sends the word MSB first.
// Depends on tjs_pkg for the control struct and the alignment helper.
`timescale 1ns / 1ps
`default_nettype none

module tjs_tdi_shifter (
  input  wire                      clk_i,
  input  wire tjs_pkg::tjs_shift_ctrl_t ctrl_i,
  input  wire  [31:0]              data_i,
  output logic                     tdi_o
);
  import tjs_pkg::*;

  logic [WORD_W-1:0] sreg_q, sreg_d;

  always_comb begin
    sreg_d = sreg_q;
    if (ctrl_i.load) begin
      sreg_d = align_top(ctrl_i.fmt, data_i);
    end else if (ctrl_i.advance) begin
      sreg_d = {sreg_q[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    sreg_q <= sreg_d;
  end

  assign tdi_o = sreg_q[WORD_W-1];

endmodule

`default_nettype wire

FILE: hdl/tjs_tdo_capture.sv
// TDO capture: shifts the returned TDO bits in one per data cycle and
// descrambles 20-bit words. Depends on tjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tjs_tdo_capture (
  input  wire                      clk_i,
  input  wire tjs_pkg::tjs_shift_ctrl_t ctrl_i,
  input  wire  [31:0]              tdo_i,
  output logic [31:0]              word_o
);
  import tjs_pkg::*;

  logic [WORD_W-1:0] src_q, src_d;
  logic [WORD_W-1:0] cap_q, cap_d;
  tjs_fmt_e          fmt_q, fmt_d;

  always_comb begin
    src_d = src_q;
    cap_d = cap_q;
    fmt_d = fmt_q;
    if (ctrl_i.load) begin
      src_d = align_top(ctrl_i.fmt, tdo_i);
      cap_d = '0;
      fmt_d = ctrl_i.fmt;
    end else if (ctrl_i.advance) begin
      src_d = {src_q[WORD_W-2:0], 1'b0};
      cap_d = {cap_q[WORD_W-2:0], src_q[WORD_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    cap_q <= cap_d;
    fmt_q <= fmt_d;
  end

  // 20-bit words come back rotated by four bits.
  always_comb begin
    if (fmt_q == FMT_20) begin
      word_o = ((cap_q << 16) | (cap_q >> 4)) & DESCR_MASK;
    end else begin
      word_o = cap_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/two_wire_jtag_scan_shifter_top.sv
// Usage: master side of a two-wire JTAG link. Commands arrive on cmd_i
// (valid/ready): shift a word of 8, 16, 20 or 32 bits, set TCLK or clear TCLK.
// Each JTAG cycle leaves as one beat on slot_o (valid/ready) with TMS, TDI,
// the TMS-slot preset flag, the TDO-sample flag and a last-cycle mark.
// A shift gives width + 2 beats: the data bits MSB first (TMS high on the
// last), an update cycle, then a return-to-idle cycle that carries the
// captured TDO word. A TCLK command gives one beat; command 3 gives none.
// The first beat follows an accepted command through the state register and
// then the beat register. Throughput: one beat per cycle while slot_o is
// ready, set by the bit-serial TDI/TDO shift registers.
// One command is worked at a time; cmd_i.ready is high only between commands.
// A stalled slot_o holds its beat and the sequencer waits.
// Reset puts the sequencer idle, drops the output beat, sets TCLK high.
// Depends on tjs_pkg, the channel interfaces and both shift modules.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_jtag_scan_shifter_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  tjs_cmd_if.sink     cmd_i,
  tjs_slot_if.source  slot_o
);
  import tjs_pkg::*;

  tjs_state_e       state_q, state_d;
  logic [CNT_W-1:0] bits_left_q, bits_left_d;
  logic             tclk_level_q, tclk_level_d;
  logic             new_level_q, new_level_d;
  tjs_fmt_e         fmt_q, fmt_d;

  logic             out_valid_q, out_valid_d;
  logic             tms_q, tdi_q, preset_q, sampled_q, last_q;
  logic [WORD_W-1:0] word_q;

  logic             cmd_fire;
  logic             out_free;
  logic             emit;
  logic             tdi_bit;
  logic [WORD_W-1:0] cap_word;
  tjs_shift_ctrl_t  ctrl;

  // slot fields of the beat being built this cycle
  logic             b_tms, b_tdi, b_preset, b_sampled, b_last;
  logic [WORD_W-1:0] b_word;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || slot_o.ready;
  assign emit        = (state_q != ST_IDLE) && out_free;

  assign ctrl.load    = cmd_fire && (tjs_cmd_e'(cmd_i.command) == CMD_SHIFT);
  assign ctrl.advance = emit && (state_q == ST_DATA);
  assign ctrl.fmt     = ctrl.load ? tjs_fmt_e'(cmd_i.shift_format) : fmt_q;

  tjs_tdi_shifter u_tdi (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .data_i (cmd_i.shift_data),
    .tdi_o  (tdi_bit)
  );

  tjs_tdo_capture u_tdo (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .tdo_i  (cmd_i.target_tdo),
    .word_o (cap_word)
  );

  // Next state.
  always_comb begin
    state_d      = state_q;
    bits_left_d  = bits_left_q;
    tclk_level_d = tclk_level_q;
    new_level_d  = new_level_q;
    fmt_d        = fmt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (tjs_cmd_e'(cmd_i.command))
            CMD_SHIFT: begin
              state_d     = ST_DATA;
              fmt_d       = tjs_fmt_e'(cmd_i.shift_format);
              bits_left_d = last_index(tjs_fmt_e'(cmd_i.shift_format));
            end
            CMD_SET_TCLK: begin
              state_d     = ST_TCLK;
              new_level_d = 1'b1;
            end
            CMD_CLR_TCLK: begin
              state_d     = ST_TCLK;
              new_level_d = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DATA: begin
        if (emit) begin
          if (bits_left_q == '0) begin
            state_d = ST_UPDATE;
          end else begin
            bits_left_d = bits_left_q - CNT_W'(1);
          end
        end
      end
      ST_UPDATE: begin
        if (emit) begin
          state_d = ST_RETURN;
        end
      end
      ST_RETURN: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      ST_TCLK: begin
        if (emit) begin
          state_d      = ST_IDLE;
          tclk_level_d = new_level_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Beat contents per state.
  always_comb begin
    b_tms     = 1'b0;
    b_tdi     = 1'b0;
    b_preset  = 1'b0;
    b_sampled = 1'b0;
    b_last    = 1'b0;
    b_word    = '0;
    case (state_q)
      ST_DATA: begin
        b_tms     = (bits_left_q == '0);
        b_tdi     = tdi_bit;
        b_sampled = 1'b1;
      end
      ST_UPDATE: begin
        b_tms = 1'b1;
        b_tdi = 1'b1;
      end
      ST_RETURN: begin
        b_tdi  = tclk_level_q;
        b_last = 1'b1;
        b_word = cap_word;
      end
      ST_TCLK: begin
        b_tdi    = new_level_q;
        b_preset = tclk_level_q;
        b_last   = 1'b1;
      end
      default: b_last = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (slot_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bits_left_q  <= '0;
      tclk_level_q <= 1'b1;
      new_level_q  <= 1'b1;
      fmt_q        <= FMT_8;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bits_left_q  <= bits_left_d;
      tclk_level_q <= tclk_level_d;
      new_level_q  <= new_level_d;
      fmt_q        <= fmt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the beat until the next one is built.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      tms_q     <= b_tms;
      tdi_q     <= b_tdi;
      preset_q  <= b_preset;
      sampled_q <= b_sampled;
      last_q    <= b_last;
      word_q    <= b_word;
    end
  end

  assign slot_o.valid                = out_valid_q;
  assign slot_o.slot_tms             = tms_q;
  assign slot_o.slot_tdi             = tdi_q;
  assign slot_o.tms_slot_preset_high = preset_q;
  assign slot_o.tdo_sampled          = sampled_q;
  assign slot_o.last_cycle           = last_q;
  assign slot_o.captured_word        = word_q;

  a_sampled_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_o.valid && slot_o.tdo_sampled |-> !slot_o.last_cycle)
    else $error("TDO-sampled beat marked as last");

  a_word_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_o.valid && !slot_o.last_cycle |-> slot_o.captured_word == '0)
    else $error("captured word on a non-final beat");

  a_shift_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |=> state_q == ST_DATA)
    else $error("shift command did not start data cycles");

  a_return_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE && emit |=> state_q == ST_RETURN && slot_o.valid && slot_o.slot_tms)
    else $error("update beat not followed by return-to-idle");

endmodule

`default_nettype wire
